### rtl/nsg_pkg.sv
// Shared types, widths and codes for the near segment gate.
package nsg_pkg;

   // Coordinate format: signed Q.10 metres.
   localparam int CW = 32;
   // Width of squared lengths and dot products in Q.20.
   localparam int LW = 2 * CW + 4;
   // Divider operands are brought down to this many bits.
   localparam int NORM_BITS = 46;
   localparam int SHIFT_W = 7;
   // Quotient bits: mu runs from 0 to 1.0 in Q.16.
   localparam int DIV_STEPS = 17;
   localparam int MU_W = 17;
   localparam logic [MU_W-1:0] MU_ONE = 17'h10000;
   // Width of the nearest point coordinates.
   localparam int NW = CW + 3;
   // Matrix entry width, Q1.14.
   localparam int ME_W = 16;

   // Gate limits in Q.10 and Q.20.
   localparam int DEGEN_Q20 = 1049;
   localparam int X_LIMIT = 60 * 1024;
   localparam int Y_LIMIT = 10 * 1024;
   localparam logic [33:0] ELLIPSE_LIMIT = 34'd3600 << 20;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Z = 3'd6;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [ME_W-1:0] mat_entry_type;

   typedef enum logic [1:0] {
      VERDICT_KEPT    = 2'd0,
      VERDICT_DEGEN   = 2'd1,
      VERDICT_BEHIND  = 2'd2,
      VERDICT_OUTSIDE = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      MU_ZERO = 2'd0,
      MU_FULL = 2'd1,
      MU_DIV  = 2'd2
   } mu_mode_type;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_z;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic       near;
      logic [1:0] verdict;
   } rsp_type;

   // Data that rides alongside the divider.
   typedef struct packed {
      logic                 degen;
      mu_mode_type          mode;
      logic signed [CW-1:0] f0;
      logic signed [CW-1:0] f1;
      logic signed [CW:0]   t0;
      logic signed [CW:0]   t1;
   } side_type;

endpackage

### rtl/near_segment_gate_top.sv
// Top level of the near segment gate: registers, segment geometry and pipeline control.
//
// Usage: each req beat carries one map segment (start and end points, Q.10 metres).
// Each segment yields exactly one rsp beat: near, and a verdict of kept, degenerate
// length, behind the vehicle or outside the gating ellipse. Results leave in order.
// The pose (quaternion rot_*, Q1.14, and translation shift_*) is written through the
// csr port, one register per write, while no segment is in flight.
// One segment enters per cycle while req_stall is low.
// The length of the pipe is set by the mu divider, which yields one quotient bit per
// stage over 17 stages, plus rotation, dot products, normalization and the final test.
// When rsp_stall holds a finished beat, the whole pipe freezes and req_stall rises in
// the same cycle, so nothing is dropped or repeated.
// Reset loads the identity pose and zero shift and empties the pipe.
module near_segment_gate_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  nsg_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nsg_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [nsg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nsg_pkg::CW-1:0]            csr_data
);
   import nsg_pkg::*;

   localparam int TW = 2 * CW + 2;

   logic adv;

   // Configuration registers.
   logic signed [15:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   coord_type shift_ff [3];
   mat_entry_type mat_ff [9];
   mat_entry_type mat_in [9];

   // Input register.
   logic s0_vld_ff;
   coord_type pt_ff [6];

   // Rotation outputs.
   logic rot_vld;
   coord_type veh [6];

   // Tangent stage.
   logic s4_vld_ff;
   coord_type f4_ff [3];
   logic signed [CW:0] t4_ff [3];
   // Product stage.
   logic s5_vld_ff;
   logic signed [TW-1:0] tt_ff [3];
   logic signed [TW-1:0] ft_ff [3];
   coord_type f5_ff [2];
   logic signed [CW:0] t5_ff [2];
   // Sum stage.
   logic s6_vld_ff;
   logic [LW-1:0] len_ff;
   logic signed [LW-1:0] s_ff;
   coord_type f6_ff [2];
   logic signed [CW:0] t6_ff [2];
   // Mode and normalization count.
   logic s7_vld_ff;
   logic [LW-1:0] len7_ff;
   logic [LW-1:0] s7_ff;
   logic [SHIFT_W-1:0] sh7_ff, sh7_in;
   side_type side7_ff, side7_in;
   // Normalized divider operands.
   logic s8_vld_ff;
   logic [NORM_BITS-1:0] num8_ff, den8_ff;
   side_type side8_ff;

   // Divider outputs.
   logic div_vld;
   logic [MU_W-1:0] quo;
   side_type div_side;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= 16'sd16384;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
         shift_ff <= '{default: '0};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROT_W:   rot_w_ff    <= csr_data[15:0];
            CSR_ROT_X:   rot_x_ff    <= csr_data[15:0];
            CSR_ROT_Y:   rot_y_ff    <= csr_data[15:0];
            CSR_ROT_Z:   rot_z_ff    <= csr_data[15:0];
            CSR_SHIFT_X: shift_ff[0] <= csr_data;
            CSR_SHIFT_Y: shift_ff[1] <= csr_data;
            CSR_SHIFT_Z: shift_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Transposed rotation matrix from the quaternion, rounded to Q.14 and clamped.
   function automatic mat_entry_type mat_round(input logic signed [34:0] q);
      logic signed [34:0] r;
      logic signed [20:0] v;
      r = q + 35'sd8192;
      v = r[34:14];
      if (v > 21'sd16384) begin
         return 16'sd16384;
      end
      if (v < -21'sd16384) begin
         return -16'sd16384;
      end
      return v[15:0];
   endfunction

   always_comb begin
      logic signed [34:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      ww = 35'(rot_w_ff) * 35'(rot_w_ff);
      xx = 35'(rot_x_ff) * 35'(rot_x_ff);
      yy = 35'(rot_y_ff) * 35'(rot_y_ff);
      zz = 35'(rot_z_ff) * 35'(rot_z_ff);
      xy = 35'(rot_x_ff) * 35'(rot_y_ff);
      xz = 35'(rot_x_ff) * 35'(rot_z_ff);
      yz = 35'(rot_y_ff) * 35'(rot_z_ff);
      wx = 35'(rot_w_ff) * 35'(rot_x_ff);
      wy = 35'(rot_w_ff) * 35'(rot_y_ff);
      wz = 35'(rot_w_ff) * 35'(rot_z_ff);
      mat_in[0] = mat_round(ww + xx - yy - zz);
      mat_in[1] = mat_round((xy + wz) <<< 1);
      mat_in[2] = mat_round((xz - wy) <<< 1);
      mat_in[3] = mat_round((xy - wz) <<< 1);
      mat_in[4] = mat_round(ww - xx + yy - zz);
      mat_in[5] = mat_round((yz + wx) <<< 1);
      mat_in[6] = mat_round((xz + wy) <<< 1);
      mat_in[7] = mat_round((yz - wx) <<< 1);
      mat_in[8] = mat_round(ww - xx - yy + zz);
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= req_data.start_x;
         pt_ff[1] <= req_data.start_y;
         pt_ff[2] <= req_data.start_z;
         pt_ff[3] <= req_data.end_x;
         pt_ff[4] <= req_data.end_y;
         pt_ff[5] <= req_data.end_z;
      end
   end

   nsg_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_vld_ff),
      .pt        (pt_ff),
      .mat       (mat_ff),
      .shift     (shift_ff),
      .out_valid (rot_vld),
      .veh       (veh)
   );

   // Mode and normalization count: mu is zero, one, or a quotient.
   always_comb begin
      logic [SHIFT_W-1:0] bl;
      bl = '0;
      for (int i = 0; i < LW; i++) begin
         if (len_ff[i]) begin
            bl = SHIFT_W'(i + 1);
         end
      end
      sh7_in = (bl > SHIFT_W'(NORM_BITS)) ? SHIFT_W'(bl - SHIFT_W'(NORM_BITS)) : '0;
      side7_in.degen = len_ff < LW'(DEGEN_Q20);
      if (s_ff[LW-1] || s_ff == '0) begin
         side7_in.mode = MU_ZERO;
      end else if (s_ff >= $signed(len_ff)) begin
         side7_in.mode = MU_FULL;
      end else begin
         side7_in.mode = MU_DIV;
      end
      side7_in.f0 = f6_ff[0];
      side7_in.f1 = f6_ff[1];
      side7_in.t0 = t6_ff[0];
      side7_in.t1 = t6_ff[1];
   end

   // Geometry stages from tangent to divider operands.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= rot_vld;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f4_ff[i] <= veh[i];
            t4_ff[i] <= (CW + 1)'(veh[i + 3]) - (CW + 1)'(veh[i]);
            tt_ff[i] <= TW'(t4_ff[i]) * TW'(t4_ff[i]);
            ft_ff[i] <= TW'(f4_ff[i]) * TW'(t4_ff[i]);
         end
         for (int i = 0; i < 2; i++) begin
            f5_ff[i] <= f4_ff[i];
            t5_ff[i] <= t4_ff[i];
            f6_ff[i] <= f5_ff[i];
            t6_ff[i] <= t5_ff[i];
         end
         len_ff   <= LW'(tt_ff[0]) + LW'(tt_ff[1]) + LW'(tt_ff[2]);
         s_ff     <= -(LW'(ft_ff[0]) + LW'(ft_ff[1]) + LW'(ft_ff[2]));
         len7_ff  <= len_ff;
         s7_ff    <= s_ff;
         sh7_ff   <= sh7_in;
         side7_ff <= side7_in;
         num8_ff  <= NORM_BITS'(s7_ff >> sh7_ff);
         den8_ff  <= NORM_BITS'(len7_ff >> sh7_ff);
         side8_ff <= side7_ff;
      end
   end

   nsg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s8_vld_ff),
      .num       (num8_ff),
      .den       (den8_ff),
      .side_in   (side8_ff),
      .out_valid (div_vld),
      .quo       (quo),
      .side_out  (div_side)
   );

   nsg_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_vld),
      .quo       (quo),
      .side      (div_side),
      .out_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // The near flag and the verdict agree on every result.
   a_near_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.near == (rsp_data.verdict == VERDICT_KEPT)))
      else $error("near flag disagrees with verdict");

   // The pipe is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A taken result always lets the pipe move.
   a_drain_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> !req_stall)
      else $error("pipe frozen while output drains");

endmodule

### rtl/nsg_rotate.sv
// Three stage translate and rotate of both segment points into the vehicle frame.
module nsg_rotate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  nsg_pkg::coord_type    pt [6],
   input  nsg_pkg::mat_entry_type mat [9],
   input  nsg_pkg::coord_type    shift [3],
   output logic                  out_valid,
   output nsg_pkg::coord_type    veh [6]
);
   import nsg_pkg::*;

   localparam int SW = CW + 5;
   localparam int PW = CW + ME_W;
   localparam int AW = CW + 18;

   logic [2:0] vld_ff;
   coord_type d_ff [6];
   coord_type d_in [6];
   logic signed [PW-1:0] prod_ff [18];
   logic signed [PW-1:0] prod_in [18];
   coord_type veh_ff [6];
   coord_type veh_in [6];

   // Clamp a wider signed value to the coordinate range.
   function automatic coord_type sat_coord(input logic signed [SW-1:0] v);
      logic same;
      same = (&v[SW-1:CW-1]) || !(|v[SW-1:CW-1]);
      if (same) begin
         return v[CW-1:0];
      end
      return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   endfunction

   // Stage one: subtract the translation with saturation.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         d_in[k] = sat_coord(SW'(pt[k]) - SW'(shift[k % 3]));
      end
   end

   // Stage two: all matrix by difference products.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_in[k * 9 + i * 3 + j] = PW'(mat[i * 3 + j]) * PW'(d_ff[k * 3 + j]);
            end
         end
      end
   end

   // Stage three: row sums, round half up from Q.24 and saturate.
   always_comb begin
      logic signed [AW-1:0] acc;
      for (int k = 0; k < 2; k++) begin
         for (int i = 0; i < 3; i++) begin
            acc = AW'(prod_ff[k * 9 + i * 3]) + AW'(prod_ff[k * 9 + i * 3 + 1])
                + AW'(prod_ff[k * 9 + i * 3 + 2]) + AW'(8192);
            veh_in[k * 3 + i] = sat_coord(SW'(acc >>> 14));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= d_in;
         prod_ff <= prod_in;
         veh_ff  <= veh_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign veh       = veh_ff;

endmodule

### rtl/nsg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for the factor mu.
module nsg_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [nsg_pkg::NORM_BITS-1:0] num,
   input  logic [nsg_pkg::NORM_BITS-1:0] den,
   input  nsg_pkg::side_type           side_in,
   output logic                        out_valid,
   output logic [nsg_pkg::MU_W-1:0]    quo,
   output nsg_pkg::side_type           side_out
);
   import nsg_pkg::*;

   localparam int NB = NORM_BITS;
   localparam int RS = DIV_STEPS - 1;

   logic [DIV_STEPS-1:0] vld_ff;
   logic [NB-1:0] rem_ff [RS];
   logic [NB-1:0] rem_in [RS];
   logic [NB-1:0] den_ff [RS];
   logic [NB-1:0] den_in [RS];
   logic [MU_W-1:0] q_ff [DIV_STEPS];
   logic [MU_W-1:0] q_in [DIV_STEPS];
   side_type side_ff [DIV_STEPS];
   side_type side_in_s [DIV_STEPS];

   // Each stage tries one subtraction; every stage but the first doubles the remainder before it.
   always_comb begin
      logic [NB:0] sh;
      logic        ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            sh = {1'b0, num};
            ge = num >= den;
            q_in[k] = {{(MU_W-1){1'b0}}, ge};
            side_in_s[k] = side_in;
            den_in[k] = den;
            rem_in[k] = ge ? NB'(num - den) : num;
         end else begin
            sh = {rem_ff[k - 1], 1'b0};
            ge = sh >= {1'b0, den_ff[k - 1]};
            q_in[k] = {q_ff[k - 1][MU_W-2:0], ge};
            side_in_s[k] = side_ff[k - 1];
            if (k < RS) begin
               den_in[k] = den_ff[k - 1];
               rem_in[k] = ge ? NB'(sh - {1'b0, den_ff[k - 1]}) : sh[NB-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         q_ff    <= q_in;
         side_ff <= side_in_s;
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign quo       = q_ff[DIV_STEPS-1];
   assign side_out  = side_ff[DIV_STEPS-1];

   // In the dividing case the numerator never exceeds the denominator.
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && side_out.mode == MU_DIV |-> quo <= MU_ONE)
      else $error("mu quotient above one");

endmodule

### rtl/nsg_judge.sv
// Nearest point reconstruction and ellipse test, ending in the result register.
module nsg_judge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [nsg_pkg::MU_W-1:0] quo,
   input  nsg_pkg::side_type        side,
   output logic                     out_valid,
   output nsg_pkg::rsp_type         rsp
);
   import nsg_pkg::*;

   localparam int MP = CW + 1 + MU_W + 1;
   localparam logic signed [NW-1:0] X_LIM = NW'(X_LIMIT);
   localparam logic signed [NW-1:0] Y_LIM = NW'(Y_LIMIT);

   logic [3:0] vld_ff;
   // Stage one.
   logic signed [MP-1:0] p0_ff, p1_ff, p0_in, p1_in;
   coord_type f0_ff, f1_ff;
   logic degen1_ff;
   // Stage two.
   logic signed [NW-1:0] n0_ff, n1_ff;
   logic degen2_ff;
   // Stage three.
   logic [31:0] xsq_ff;
   logic [29:0] ysq_ff;
   logic [31:0] xsq_in;
   logic [29:0] ysq_in;
   verdict_type early_ff, early_in;
   // Result register.
   rsp_type rsp_ff, rsp_in;

   // Pick mu and scale the tangent by it.
   always_comb begin
      logic [MU_W-1:0] mu;
      unique case (side.mode)
         MU_ZERO: mu = '0;
         MU_FULL: mu = MU_ONE;
         MU_DIV:  mu = quo;
         default: mu = '0;
      endcase
      p0_in = MP'(side.t0) * MP'($signed({1'b0, mu}));
      p1_in = MP'(side.t1) * MP'($signed({1'b0, mu}));
   end

   // Early verdicts and the squares of the bounded nearest point.
   always_comb begin
      logic [15:0]        xa;
      logic signed [14:0] ys;
      logic signed [29:0] yp;
      xa = n0_ff[15:0];
      ys = n1_ff[14:0];
      yp = 30'(ys) * 30'(ys);
      xsq_in = 32'(xa) * 32'(xa);
      ysq_in = yp;
      priority if (degen2_ff) begin
         early_in = VERDICT_DEGEN;
      end else if (n0_ff < 0) begin
         early_in = VERDICT_BEHIND;
      end else if (n0_ff >= X_LIM || n1_ff >= Y_LIM || n1_ff <= -Y_LIM) begin
         early_in = VERDICT_OUTSIDE;
      end else begin
         early_in = VERDICT_KEPT;
      end
   end

   // Final ellipse compare: x^2 + 36 y^2 against 3600 m^2.
   always_comb begin
      logic [33:0] sum;
      sum = 34'(xsq_ff) + (34'(ysq_ff) << 5) + (34'(ysq_ff) << 2);
      if (early_ff == VERDICT_KEPT && sum >= ELLIPSE_LIMIT) begin
         rsp_in.verdict = VERDICT_OUTSIDE;
      end else begin
         rsp_in.verdict = early_ff;
      end
      rsp_in.near = (rsp_in.verdict == VERDICT_KEPT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         f0_ff     <= side.f0;
         f1_ff     <= side.f1;
         degen1_ff <= side.degen;
         n0_ff     <= NW'(f0_ff) + NW'(p0_ff >>> 16);
         n1_ff     <= NW'(f1_ff) + NW'(p1_ff >>> 16);
         degen2_ff <= degen1_ff;
         xsq_ff    <= xsq_in;
         ysq_ff    <= ysq_in;
         early_ff  <= early_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign rsp       = rsp_ff;

endmodule

### tb/sv/near_segment_gate_top_tb.sv
// Testbench for the near segment gate: directed table, random segments, pose changes.
module near_segment_gate_top_tb;
   import nsg_pkg::*;

   localparam longint METER = 1024;
   localparam longint C_MAX = 64'sd2147483647;
   localparam longint C_MIN = -64'sd2147483648;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CW-1:0] csr_data;

   // Pose copy used by the verdict predictor.
   longint pose_rot[4];
   longint pose_shift[3];

   rsp_type verdict_queue[$];
   int errors;
   int send_idle_pct;
   int stall_pct;
   int hold_cycles;
   bit hold_go;

   typedef struct {
      req_type seg;
      bit typed;
      verdict_type verdict;
   } seg_row_type;

   seg_row_type seg_rows[$];

   near_segment_gate_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint sat_coord(longint v);
      if (v > C_MAX) return C_MAX;
      if (v < C_MIN) return C_MIN;
      return v;
   endfunction

   // Q.28 quaternion product rounded half up to Q1.14 and clamped to +-1.0.
   function automatic longint round_q14(longint v);
      longint r;
      r = (v + 8192) >>> 14;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   // Map point into the vehicle frame: shift, then rotate by the conjugate.
   function automatic void to_frame(input longint m[3][3], input longint p[3],
                                    output longint v[3]);
      longint d[3];
      longint acc;
      for (int i = 0; i < 3; i++) d[i] = sat_coord(p[i] - pose_shift[i]);
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * d[0] + m[i][1] * d[1] + m[i][2] * d[2];
         v[i] = sat_coord((acc + 8192) >>> 14);
      end
   endfunction

   function automatic verdict_type predict_verdict(req_type r);
      longint w, x, y, z;
      longint m[3][3];
      longint ps[3], pe[3], f[3], e[3], nr[3];
      logic signed [127:0] tw[3], fw[3], len2, s;
      longint mu, ut, um, part;
      int bl, n;
      w = pose_rot[0]; x = pose_rot[1]; y = pose_rot[2]; z = pose_rot[3];
      m[0][0] = round_q14(w*w + x*x - y*y - z*z);
      m[0][1] = round_q14(2 * (x*y + w*z));
      m[0][2] = round_q14(2 * (x*z - w*y));
      m[1][0] = round_q14(2 * (x*y - w*z));
      m[1][1] = round_q14(w*w - x*x + y*y - z*z);
      m[1][2] = round_q14(2 * (y*z + w*x));
      m[2][0] = round_q14(2 * (x*z + w*y));
      m[2][1] = round_q14(2 * (y*z - w*x));
      m[2][2] = round_q14(w*w - x*x - y*y + z*z);
      ps[0] = longint'(r.start_x); ps[1] = longint'(r.start_y);
      ps[2] = longint'(r.start_z);
      pe[0] = longint'(r.end_x); pe[1] = longint'(r.end_y); pe[2] = longint'(r.end_z);
      to_frame(m, ps, f);
      to_frame(m, pe, e);
      for (int i = 0; i < 3; i++) begin
         tw[i] = 128'(e[i] - f[i]);
         fw[i] = 128'(f[i]);
      end
      len2 = tw[0]*tw[0] + tw[1]*tw[1] + tw[2]*tw[2];
      if (len2 < DEGEN_Q20) return VERDICT_DEGEN;
      s = -(fw[0]*tw[0] + fw[1]*tw[1] + fw[2]*tw[2]);
      if (s <= 0) mu = 0;
      else if (s >= len2) mu = 65536;
      else begin
         // Bring both operands down so the divisor has at most 46 bits.
         bl = 0;
         for (int i = 0; i < 128; i++) if (len2[i]) bl = i + 1;
         n = bl - NORM_BITS;
         if (n > 0) begin
            len2 = len2 >>> n;
            s = s >>> n;
         end
         mu = longint'((s <<< 16) / len2);
      end
      for (int i = 0; i < 3; i++) begin
         ut = (e[i] >= f[i]) ? e[i] - f[i] : f[i] - e[i];
         um = ut * mu;
         part = (e[i] >= f[i]) ? (um >> 16) : -((um + 65535) >> 16);
         nr[i] = f[i] + part;
      end
      if (nr[0] < 0) return VERDICT_BEHIND;
      if (nr[0] >= X_LIMIT || nr[1] >= Y_LIMIT || nr[1] <= -Y_LIMIT)
         return VERDICT_OUTSIDE;
      if (nr[0]*nr[0] + 36*nr[1]*nr[1] < (longint'(3600) << 20)) return VERDICT_KEPT;
      return VERDICT_OUTSIDE;
   endfunction

   function automatic req_type make_seg(longint sx, longint sy, longint sz,
                                        longint ex, longint ey, longint ez);
      req_type r;
      r.start_x = CW'(sat_coord(sx)); r.start_y = CW'(sat_coord(sy));
      r.start_z = CW'(sat_coord(sz));
      r.end_x = CW'(sat_coord(ex)); r.end_y = CW'(sat_coord(ey));
      r.end_z = CW'(sat_coord(ez));
      return r;
   endfunction

   function automatic longint rand_full();
      return longint'(signed'($urandom()));
   endfunction

   function automatic longint rand_span(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   // Mostly segments near the vehicle, some short ones and some anywhere.
   function automatic req_type random_seg();
      int pick;
      longint sx, sy, sz;
      pick = $urandom_range(99);
      if (pick < 12)
         return make_seg(rand_full(), rand_full(), rand_full(),
                         rand_full(), rand_full(), rand_full());
      sx = pose_shift[0] + rand_span(90 * METER);
      sy = pose_shift[1] + rand_span(90 * METER);
      sz = pose_shift[2] + rand_span(5 * METER);
      if (pick < 24)
         return make_seg(sx, sy, sz, sx + rand_span(20), sy + rand_span(20), sz + rand_span(20));
      if (pick < 40)
         return make_seg(sx, sy, sz, sx + rand_span(3 * METER), sy + rand_span(3 * METER),
                         sz + rand_span(METER));
      return make_seg(sx, sy, sz, pose_shift[0] + rand_span(90 * METER),
                      pose_shift[1] + rand_span(90 * METER),
                      pose_shift[2] + rand_span(5 * METER));
   endfunction

   // Register write; also updates the predictor's pose.
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, longint value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CW-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx <= CSR_ROT_Z) pose_rot[idx] = longint'(signed'(value[15:0]));
      else pose_shift[idx - CSR_SHIFT_X] = longint'(signed'(value[CW-1:0]));
   endtask

   task automatic drain();
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_pose(longint w, longint x, longint y, longint z,
                           longint tx, longint ty, longint tz);
      drain();
      csr_put(CSR_ROT_W, w);
      csr_put(CSR_ROT_X, x);
      csr_put(CSR_ROT_Y, y);
      csr_put(CSR_ROT_Z, z);
      csr_put(CSR_SHIFT_X, tx);
      csr_put(CSR_SHIFT_Y, ty);
      csr_put(CSR_SHIFT_Z, tz);
   endtask

   // Offer one beat and hold it until the block takes it.
   task automatic send_seg(req_type r, bit typed, verdict_type typed_verdict);
      rsp_type exp;
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      v = typed ? typed_verdict : predict_verdict(r);
      exp.near = (v == VERDICT_KEPT);
      exp.verdict = v;
      verdict_queue.insert(verdict_queue.size(), exp);
      @(posedge clock);
   endtask

   // Result checker: a beat is taken at the next edge when valid and not stalled.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected result beat near=%0b verdict=%0d",
                     $time, rsp_data.near, rsp_data.verdict);
            errors++;
         end else begin
            if (rsp_data !== verdict_queue[0]) begin
               $display("%0t: mismatch expected near=%0b verdict=%0d, got near=%0b verdict=%0d",
                        $time, verdict_queue[0].near, verdict_queue[0].verdict,
                        rsp_data.near, rsp_data.verdict);
               errors++;
            end
            void'(verdict_queue.pop_front());
         end
      end
   end

   // Result side back-pressure, with a single long hold in phase four.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_cycles = 300;
         hold_go = 1'b0;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      #(20 * 400000);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      real ang;
      int sends;
      errors = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      hold_go = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      pose_rot[0] = 16384; pose_rot[1] = 0; pose_rot[2] = 0; pose_rot[3] = 0;
      pose_shift[0] = 0; pose_shift[1] = 0; pose_shift[2] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed segments under the reset pose.
      seg_rows = '{
         '{make_seg(0, 0, 0, 0, 0, 0), 1, VERDICT_DEGEN},
         '{make_seg(-10*METER, 5*METER, 0, -5*METER, 5*METER, 0), 1, VERDICT_BEHIND},
         '{make_seg(10*METER, 0, 0, 20*METER, 0, 0), 1, VERDICT_KEPT},
         '{make_seg(100*METER, 0, 0, 110*METER, 0, 0), 1, VERDICT_OUTSIDE},
         '{make_seg(-10*METER, -3*METER, 0, 10*METER, -3*METER, 0), 1, VERDICT_KEPT},
         '{make_seg(0, -20*METER, 0, 0, 20*METER, 0), 1, VERDICT_KEPT},
         '{make_seg(0, 10*METER, 0, METER, 10*METER, 0), 1, VERDICT_OUTSIDE},
         '{make_seg(0, 0, 0, 32, 0, 0), 1, VERDICT_DEGEN},
         '{make_seg(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1, VERDICT_DEGEN},
         '{make_seg(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1, VERDICT_DEGEN},
         '{make_seg(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 0, VERDICT_KEPT},
         '{make_seg(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0, VERDICT_KEPT},
         '{make_seg(C_MIN, C_MAX, 0, C_MAX, C_MIN, 0), 0, VERDICT_KEPT},
         '{make_seg(0, 0, 0, 41, 0, 0), 0, VERDICT_KEPT},
         '{make_seg(61439, -5*METER, 0, 61439, 5*METER, 0), 0, VERDICT_KEPT},
         '{make_seg(59*METER, -2*METER, 0, 59*METER, 2*METER, 0), 0, VERDICT_KEPT},
         '{make_seg(-METER, 10239, C_MAX, METER, 10239, C_MIN), 0, VERDICT_KEPT},
         '{make_seg(5*METER, -9*METER, 0, 60*METER, 9*METER, 0), 0, VERDICT_KEPT}
      };
      foreach (seg_rows[i]) send_seg(seg_rows[i].seg, seg_rows[i].typed, seg_rows[i].verdict);
      req_valid <= 1'b0;

      // Pose extremes, then random poses, with idle and stall patterns that repeat every four phases.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_pose(-16384, 16384, -16384, 16384, C_MAX, C_MIN, C_MAX);
            1: set_pose(16384, 0, 0, 0, C_MIN, C_MAX, C_MIN);
            2: set_pose(0, 0, 0, 16384, 0, 0, 0);
            3: set_pose(rand_span(16384), rand_span(16384), rand_span(16384),
                        rand_span(16384), rand_full(), rand_full(), rand_full());
            default: begin
               ang = ($urandom_range(6283) / 1000.0) / 2.0;
               set_pose(longint'($rtoi(16384.0 * $cos(ang))), rand_span(200), rand_span(200),
                        longint'($rtoi(16384.0 * $sin(ang))), rand_span(500 * METER),
                        rand_span(500 * METER), rand_span(10 * METER));
            end
         endcase
         send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 3) ? 29 : 80) : 0;
         stall_pct = (phase % 4 == 2) ? 80 : ((phase % 4 == 3) ? 29 : 0);
         sends = (phase < 4) ? 50 : 100;
         for (int k = 0; k < sends; k++) begin
            // Long receiver hold while the sender keeps pushing.
            if (phase == 4 && k == 10) hold_go = 1'b1;
            // Sender waits until the pipe has fully emptied.
            if (phase == 5 && k == 50) begin
               req_valid <= 1'b0;
               while (verdict_queue.size() != 0) @(posedge clock);
            end
            send_seg(random_seg(), 0, VERDICT_KEPT);
         end
         req_valid <= 1'b0;
      end

      stall_pct = 0;
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
